// File: rtl/bfr_pkg.sv
package bfr_pkg;

  localparam int DEPTH_DEF     = 4096;
  localparam int MAX_BURST_DEF = 64;
  localparam int CAP_RESET     = 4096;

  localparam logic [2:0] REQ_WRITE = 3'd0;
  localparam logic [2:0] REQ_READ  = 3'd1;
  localparam logic [2:0] REQ_PEEK  = 3'd2;
  localparam logic [2:0] REQ_SKIP  = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_BADLEN  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic step;
    logic cfg_we;
  } bfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stream_go;
    logic stream_last;
  } bfr_stat_t;

endpackage

// File: rtl/bfr_ctrl.sv
module bfr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              cfg_valid,
  input  bfr_pkg::bfr_stat_t stat,
  output bfr_pkg::bfr_cmd_t  cmd,
  output logic              busy,
  output logic              cfg_ready
);
  import bfr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_STREAM = 2'b10
  } state_t;

  state_t state, state_next;

  // A request and a capacity write never share an edge; the request wins.
  always_comb begin
    cmd.accept = start && (state == ST_IDLE);
    cmd.step   = (state == ST_STREAM);
    cfg_ready  = (state == ST_IDLE) && !start;
    cmd.cfg_we = cfg_valid && cfg_ready;
    busy       = (state == ST_STREAM);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.accept && stat.stream_go) state_next = ST_STREAM;
      end
      ST_STREAM: begin
        if (stat.stream_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/bfr_datapath.sv
module bfr_datapath #(
  parameter int DEPTH     = bfr_pkg::DEPTH_DEF,
  parameter int MAX_BURST = bfr_pkg::MAX_BURST_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bfr_pkg::bfr_cmd_t  cmd,
  output bfr_pkg::bfr_stat_t stat,
  input  logic [12:0]        cfg_data,
  input  logic [2:0]         req_type,
  input  logic [12:0]        req_len,
  input  logic               burst_first,
  input  logic [7:0]         data_byte,
  output logic               strobe,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               last,
  output logic [12:0]        done_count,
  output logic [1:0]         status,
  output logic [12:0]        fill_level
);
  import bfr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = ($clog2(DEPTH + 1) > 13) ? $clog2(DEPTH + 1) : 13;
  localparam int KW = $clog2(MAX_BURST + 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [CW-1:0] CAP_INIT = (CAP_RESET > DEPTH) ? CW'(DEPTH) : CW'(CAP_RESET);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    mem_q;

  logic [CW-1:0] cap;
  logic [AW-1:0] wp, rp, scan;
  logic [CW-1:0] held;
  logic [12:0]   burst_left;
  logic          burst_rej;
  logic [KW-1:0] remaining;
  logic [KW-1:0] stream_k;
  logic [12:0]   stream_fill;
  logic          stream_read;

  logic          from_mem;
  logic          res_last;
  logic [12:0]   res_done;
  logic [1:0]    res_status;
  logic [12:0]   res_fill;

  logic [AW-1:0] wp_next, rp_next;
  logic [CW-1:0] held_next;
  logic [12:0]   burst_left_next;
  logic          burst_rej_next;
  logic          wr_store;
  logic          go;
  logic [CW-1:0] imm_done;
  logic [1:0]    imm_status;

  logic [CW-1:0] len_x, kx, cfg_x, cap_cfg;
  logic [CW-1:0] wp_inc, scan_inc;
  logic [CW:0]   skip_sum;
  logic [AW-1:0] wp_adv, scan_adv, skip_ptr;

  always_comb begin
    len_x    = CW'(req_len);
    kx       = (len_x > held) ? held : len_x;
    wp_inc   = CW'(wp) + CW'(1);
    wp_adv   = (wp_inc >= cap) ? '0 : wp_inc[AW-1:0];
    scan_inc = CW'(scan) + CW'(1);
    scan_adv = (scan_inc >= cap) ? '0 : scan_inc[AW-1:0];
    // Pointer is below capacity and length at most capacity, so one subtract wraps.
    skip_sum = (CW+1)'(rp) + (CW+1)'(len_x);
    skip_ptr = (skip_sum >= (CW+1)'(cap)) ? AW'(skip_sum - (CW+1)'(cap)) : AW'(skip_sum);
    cfg_x    = CW'(cfg_data);
    if (cfg_x == '0) begin
      cap_cfg = CW'(1);
    end else if (cfg_x > DEPTH_C) begin
      cap_cfg = DEPTH_C;
    end else begin
      cap_cfg = cfg_x;
    end
  end

  always_comb begin
    wp_next         = wp;
    rp_next         = rp;
    held_next       = held;
    burst_left_next = burst_left;
    burst_rej_next  = burst_rej;
    wr_store        = 1'b0;
    go              = 1'b0;
    imm_done        = '0;
    imm_status      = STAT_OK;
    case (req_type)
      REQ_WRITE: begin
        if (burst_first) begin
          burst_left_next = '0;
          burst_rej_next  = 1'b0;
          if (req_len == '0) begin
            imm_status = STAT_BADLEN;
          end else if (held > cap || len_x > cap - held) begin
            burst_rej_next  = 1'b1;
            burst_left_next = req_len - 13'd1;
            imm_status      = STAT_NOSPACE;
          end else begin
            burst_left_next = req_len;
          end
        end else if (burst_left == '0) begin
          imm_status = STAT_BADLEN;
        end else if (burst_rej) begin
          burst_left_next = burst_left - 13'd1;
          if (burst_left_next == '0) burst_rej_next = 1'b0;
          imm_status = STAT_NOSPACE;
        end
        if (imm_status == STAT_OK && burst_left_next != '0 && !burst_rej_next) begin
          burst_left_next = burst_left_next - 13'd1;
          if (held < cap) begin
            wr_store  = 1'b1;
            wp_next   = wp_adv;
            held_next = held + CW'(1);
            imm_done  = CW'(1);
          end else begin
            imm_status = STAT_NOSPACE;
          end
        end
      end
      REQ_READ, REQ_PEEK: begin
        if (req_len > 13'(MAX_BURST)) begin
          imm_status = STAT_BADLEN;
        end else if (req_type == REQ_PEEK && len_x > held) begin
          imm_done = held;
        end else if (kx != '0) begin
          go = 1'b1;
          if (req_type == REQ_READ) held_next = held - kx;
        end
      end
      REQ_SKIP: begin
        if (len_x > held) begin
          imm_done = held;
        end else begin
          rp_next   = skip_ptr;
          held_next = held - len_x;
          imm_done  = len_x;
        end
      end
      REQ_CLEAR: begin
        wp_next         = '0;
        rp_next         = '0;
        held_next       = '0;
        burst_left_next = '0;
        burst_rej_next  = 1'b0;
      end
      default: imm_status = STAT_BADLEN;
    endcase
  end

  always_comb begin
    stat.stream_go   = go;
    stat.stream_last = (remaining == KW'(1));
  end

  // Single-port store: writes happen on accepted items, reads only while streaming.
  always_ff @(posedge clk) begin
    if (cmd.accept && !cmd.cfg_we && wr_store) mem[wp] <= data_byte;
    if (cmd.step) mem_q <= mem[scan];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap        <= CAP_INIT;
      wp         <= '0;
      rp         <= '0;
      held       <= '0;
      burst_left <= '0;
      burst_rej  <= 1'b0;
      remaining  <= '0;
      strobe     <= 1'b0;
      from_mem   <= 1'b0;
    end else begin
      strobe   <= 1'b0;
      from_mem <= 1'b0;
      if (cmd.cfg_we) begin
        cap        <= cap_cfg;
        wp         <= '0;
        rp         <= '0;
        held       <= '0;
        burst_left <= '0;
        burst_rej  <= 1'b0;
      end else if (cmd.accept) begin
        wp         <= wp_next;
        rp         <= rp_next;
        held       <= held_next;
        burst_left <= burst_left_next;
        burst_rej  <= burst_rej_next;
        if (go) begin
          remaining <= KW'(kx);
        end else begin
          strobe <= 1'b1;
        end
      end else if (cmd.step) begin
        strobe    <= 1'b1;
        from_mem  <= 1'b1;
        remaining <= remaining - KW'(1);
        if (remaining == KW'(1) && stream_read) rp <= scan_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan        <= rp;
      stream_k    <= KW'(kx);
      stream_fill <= 13'(held_next);
      stream_read <= (req_type == REQ_READ);
      res_last    <= 1'b1;
      res_done    <= 13'(imm_done);
      res_status  <= imm_status;
      res_fill    <= 13'(held_next);
    end else if (cmd.step) begin
      scan       <= scan_adv;
      res_last   <= (remaining == KW'(1));
      res_done   <= 13'(stream_k);
      res_status <= STAT_OK;
      res_fill   <= stream_fill;
    end
  end

  always_comb begin
    out_byte   = from_mem ? mem_q : 8'd0;
    byte_valid = from_mem;
    last       = res_last;
    done_count = res_done;
    status     = res_status;
    fill_level = res_fill;
  end

endmodule

// File: rtl/byte_ring_fifo_top.sv
// Byte ring FIFO. A request is taken when start is high and busy is low, and its
// results come out one per cycle, each marked by strobe for a single cycle; the
// receiver cannot stall them. Write, skip, clear and refused requests, and reads or
// peeks that stream no bytes, give a single result in the cycle after the request;
// busy stays low, so requests may follow back to back. A read or peek of k bytes
// holds busy high while it returns k results, the one read port of the store
// delivering one registered byte per cycle. Writing the capacity register resets
// the pointers and the fill count; it is taken only while busy is low.
module byte_ring_fifo_top #(
  parameter int DEPTH     = bfr_pkg::DEPTH_DEF,
  parameter int MAX_BURST = bfr_pkg::MAX_BURST_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [12:0] req_len,
  input  logic        burst_first,
  input  logic [7:0]  data_byte,
  output logic        strobe,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last,
  output logic [12:0] done_count,
  output logic [1:0]  status,
  output logic [12:0] fill_level,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);
  import bfr_pkg::*;

  bfr_cmd_t  cmd;
  bfr_stat_t stat;

  bfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_valid (cfg_valid),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_ready (cfg_ready)
  );

  bfr_datapath #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_data    (cfg_data),
    .req_type    (req_type),
    .req_len     (req_len),
    .burst_first (burst_first),
    .data_byte   (data_byte),
    .strobe      (strobe),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .last        (last),
    .done_count  (done_count),
    .status      (status),
    .fill_level  (fill_level)
  );

endmodule
